>>> sv/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ple_pkg;

  // Fixed field widths of the word on each channel.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Decoded operation handed from the decoder to the list storage.
  typedef struct packed {
    logic ins;
    logic rem;
    logic rd;
  } ple_cmd_t;

endpackage

`default_nettype wire

>>> sv/ple_decode.sv
// Request decoder: checks position and fill level and picks the status.
// Depends on ple_pkg.
`default_nettype none

module ple_decode #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned LEN_W    = 5
) (
  input  wire logic [ple_pkg::REQ_W-1:0]  req_type,
  input  wire logic [ple_pkg::POS_W-1:0]  position,
  input  wire logic [LEN_W-1:0]           length,
  output      logic [ple_pkg::STAT_W-1:0] status,
  output      ple_pkg::ple_cmd_t          cmd
);
  import ple_pkg::*;

  localparam int unsigned CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] len_x;
  logic             pos_zero;
  logic             past_end;
  logic             past_tail;
  logic             is_full;
  logic             is_empty;

  assign pos_x     = CMP_W'(position);
  assign len_x     = CMP_W'(length);
  assign pos_zero  = (position == '0);
  assign past_end  = (pos_x > len_x);
  assign past_tail = (pos_x > (len_x + CMP_W'(1)));
  assign is_full   = (len_x >= CAP_C);
  assign is_empty  = (length == '0);

  always_comb begin
    status = ST_OK;
    cmd    = '0;
    case (req_type)
      REQ_INSERT: begin
        if (pos_zero || past_tail) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // The empty check takes priority over the position check.
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_zero || past_end) begin
          status = ST_RANGE;
        end else begin
          cmd.rem = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_zero || past_end) begin
          status = ST_RANGE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ple_store.sv
// List storage: one register per entry that holds, shifts or loads in parallel,
// plus the entry count. Depends on ple_pkg.
`default_nettype none

module ple_store #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned LEN_W    = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ple_pkg::ple_cmd_t                  cmd,
  input  wire logic [ple_pkg::POS_W-1:0]          position,
  input  wire logic signed [ple_pkg::DATA_W-1:0]  value,
  output      logic signed [ple_pkg::DATA_W-1:0]  rd_data,
  output      logic [LEN_W-1:0]                   length,
  output      logic [LEN_W-1:0]                   len_nxt
);
  import ple_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PX_W  = POS_W + 1;

  logic signed [DATA_W-1:0] ent_r   [CAPACITY];
  logic signed [DATA_W-1:0] ent_nxt [CAPACITY];
  logic [LEN_W-1:0]         len_r;
  logic [PX_W-1:0]          pos_x;
  logic [POS_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         rd_idx;

  assign pos_x = PX_W'(position);

  // Entry i sits at position i+1. Insert moves every entry at or past the
  // position one place back; remove pulls them one place forward.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_ent
    localparam logic [PX_W-1:0] SLOT = PX_W'(i + 1);
    logic signed [DATA_W-1:0] prev_w;
    logic signed [DATA_W-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = value;
    end else begin : g_mid
      assign prev_w = ent_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = ent_r[i];
    end else begin : g_body
      assign next_w = ent_r[i+1];
    end

    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (cmd.ins && (SLOT >= pos_x)) begin
        ent_nxt[i] = (SLOT == pos_x) ? value : prev_w;
      end else if (cmd.rem && (SLOT >= pos_x)) begin
        ent_nxt[i] = next_w;
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (cmd.ins) begin
      len_nxt = len_r + LEN_W'(1);
    end else if (cmd.rem) begin
      len_nxt = len_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign pos_m1  = position - POS_W'(1);
  assign rd_idx  = pos_m1[IDX_W-1:0];
  assign rd_data = ent_r[rd_idx];
  assign length  = len_r;

endmodule

`default_nettype wire

>>> sv/positional_list_engine.sv
// Positional list engine: ordered list of signed 32-bit entries, 1-based positions.
// The input register loads when a word is accepted and the result register when
// that word moves on, which waits while a stalled result is held.
// Throughput without stalls: one word per cycle through decoder and shift network.
// Reset (rst_n low, synchronous) empties the list and drops both pipeline stages;
// entry contents are not cleared and are never read before being written.
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [ple_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [ple_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [ple_pkg::DATA_W-1:0]  in_value,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic signed [ple_pkg::DATA_W-1:0]  out_read_value,
  output      logic [ple_pkg::STAT_W-1:0]         out_status,
  output      logic [ple_pkg::COUNT_W-1:0]        out_entry_count
);
  import ple_pkg::*;

  // The count register must hold CAPACITY itself.
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

  // Input stage: the accepted word waits here until the result register is free.
  logic                     s1_valid_r;
  logic [REQ_W-1:0]         s1_req_r;
  logic [POS_W-1:0]         s1_pos_r;
  logic signed [DATA_W-1:0] s1_value_r;

  // Result stage.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic signed [DATA_W-1:0] out_read_value_nxt;
  logic [STAT_W-1:0]        out_status_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic [COUNT_W-1:0]       out_count_nxt;

  logic                     advance;
  logic                     fire;
  logic [STAT_W-1:0]        dec_status;
  ple_cmd_t                 dec_cmd;
  ple_cmd_t                 st_cmd;
  logic signed [DATA_W-1:0] rd_data;
  logic [LEN_W-1:0]         length;
  logic [LEN_W-1:0]         len_nxt;
  logic [LEN_W+COUNT_W-1:0] count_ext;

  // The result register can take a new result when it is empty or being
  // drained this cycle; the input stage can then take a new word as well.
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  ple_decode #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
  ) u_decode (
    .req_type (s1_req_r),
    .position (s1_pos_r),
    .length   (length),
    .status   (dec_status),
    .cmd      (dec_cmd)
  );

  // The list only changes when the request actually moves to the result stage,
  // so the following word always sees the updated list.
  assign st_cmd = fire ? dec_cmd : '0;

  ple_store #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (st_cmd),
    .position (s1_pos_r),
    .value    (s1_value_r),
    .rd_data  (rd_data),
    .length   (length),
    .len_nxt  (len_nxt)
  );

  // Read data is reported only for a successful read; everything else is zero.
  assign out_read_value_nxt = dec_cmd.rd ? rd_data : '0;

  // The reported count is the count after the request, kept to its low five bits.
  assign count_ext     = (LEN_W + COUNT_W)'(len_nxt);
  assign out_count_nxt = count_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r   <= in_req_type;
      s1_pos_r   <= in_position;
      s1_value_r <= in_value;
    end
    if (fire) begin
      out_read_value_r <= out_read_value_nxt;
      out_status_r     <= dec_status;
      out_count_r      <= out_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

>>> sv/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
`default_nettype none

module ple_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [ple_pkg::DATA_W-1:0]  out_read_value,
  input wire logic [ple_pkg::STAT_W-1:0]         out_status,
  input wire logic [ple_pkg::COUNT_W-1:0]        out_entry_count
);
  import ple_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // A failed request never returns list data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0))
    else $error("rejected request returned nonzero read data");

  // A full rejection only happens with the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == CAP_C))
    else $error("full status with list below capacity");

  // An empty rejection only happens with no entries held.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with entries held");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_read_value) && $stable(out_status)
       && $stable(out_entry_count)))
    else $error("stalled result word changed");

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

`default_nettype wire

>>> dv/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: insert, remove and read by position.
// Depends on ple_pkg and the positional_list_engine RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  // The list depth must match the parameter handed to the block.
  localparam int unsigned LIST_DEPTH  = 16;
  // The request field is two bits wide, so one code is left unused.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // The slowest legal run is far below this: about 730 words, each held up
  // by geometric gaps on both sides plus a two-stage pipeline.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One result word as the block should produce it.
  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } list_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [REQ_W-1:0]          in_req_type;
  logic [POS_W-1:0]          in_position;
  logic signed [DATA_W-1:0]  in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [DATA_W-1:0]  out_read_value;
  logic [STAT_W-1:0]         out_status;
  logic [COUNT_W-1:0]        out_entry_count;

  // Shadow copy of the list, updated once for every accepted request word.
  logic signed [DATA_W-1:0]  shadow_entries [LIST_DEPTH];
  int unsigned               shadow_length;

  // Results the block still owes us, oldest first.
  list_result_t              pending_results [$];

  int unsigned               error_count;
  int unsigned               cycle_count;
  // When low, neither side inserts random bubbles.
  bit                        idle_on;

  positional_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes what the block must answer for one request and applies the
  // request to the shadow list. A rejected request leaves the list alone.
  function automatic list_result_t predict_list_op(logic [REQ_W-1:0] req,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
    list_result_t res;
    int unsigned  i;
    res.read_value = '0;
    res.status     = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (pos == 0 || pos > shadow_length + 1) begin
          res.status = ST_RANGE;
        end else if (shadow_length >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Move every entry from the position to the end back by one.
          for (i = shadow_length; i >= pos; i--) begin
            shadow_entries[i] = shadow_entries[i-1];
          end
          shadow_entries[pos-1] = val;
          shadow_length++;
        end
      end
      REQ_REMOVE: begin
        // An empty list is reported before the position is looked at.
        if (shadow_length == 0) begin
          res.status = ST_EMPTY;
        end else if (pos == 0 || pos > shadow_length) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos - 1; i + 1 < shadow_length; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_length--;
        end
      end
      REQ_READ: begin
        // Reads only reach written entries, since they stop below the length.
        if (pos == 0 || pos > shadow_length) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = shadow_entries[pos-1];
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.entry_count = shadow_length[COUNT_W-1:0];
    return res;
  endfunction

  // Drives one request word, holding it until the block takes it. Random
  // bubbles go in front of the word; valid is only touched at falling edges,
  // once per edge, so a back-to-back word never sees valid dip.
  task automatic send_word(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value    <= val;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_results.push_back(predict_list_op(req, pos, val));
  endtask

  // Drops valid and holds the sender off until every owed result is back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Picks one request. Most words carry a position that is legal for the
  // current length so that the list really fills and empties; the rest use
  // any position at all. The filling flag tilts the mix toward inserts.
  task automatic issue_random_request(bit filling);
    int unsigned      roll;
    int unsigned      top;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    if (roll < 4) begin
      req = REQ_UNUSED;
    end else if (roll < (filling ? 60 : 24)) begin
      req = REQ_INSERT;
    end else if (roll < 80) begin
      req = REQ_REMOVE;
    end else begin
      req = REQ_READ;
    end
    if (req == REQ_INSERT) begin
      top = shadow_length + 1;
    end else begin
      top = (shadow_length == 0) ? 1 : shadow_length;
    end
    if (req != REQ_UNUSED && $urandom_range(99) < 85) begin
      pos = POS_W'($urandom_range(top, 1));
    end else begin
      pos = POS_W'($urandom_range(255, 0));
    end
    send_word(req, pos, DATA_W'($urandom));
  endtask

  // Every request against a list that has never held anything, including
  // position zero and the unused request code.
  task automatic test_empty_list();
    send_word(REQ_REMOVE, 8'd1, 32'sd5);
    send_word(REQ_REMOVE, 8'd0, 32'sd0);
    send_word(REQ_READ,   8'd1, 32'sd0);
    send_word(REQ_READ,   8'd0, 32'sd0);
    send_word(REQ_INSERT, 8'd0, 32'sd7);
    send_word(REQ_INSERT, 8'd2, 32'sd7);
    send_word(REQ_UNUSED, 8'd1, 32'sd9);
  endtask

  // Extreme data values at the head, the tail and the middle, with head and tail read
  // back, plus the largest position on every request type.
  task automatic test_boundary_values();
    send_word(REQ_INSERT, 8'd1,   32'sh7fffffff);
    send_word(REQ_INSERT, 8'd1,   32'sh80000000);
    send_word(REQ_INSERT, 8'd3,   -32'sd1);
    send_word(REQ_INSERT, 8'd2,   32'sd0);
    send_word(REQ_READ,   8'd1,   32'sd0);
    send_word(REQ_READ,   8'd4,   32'sd0);
    send_word(REQ_READ,   8'd255, 32'sd0);
    send_word(REQ_REMOVE, 8'd255, 32'sd0);
    send_word(REQ_INSERT, 8'd255, 32'sd1);
  endtask

  // Fills the list to capacity, then probes it: a legal position while full
  // must report full, one past the legal range must report out of range.
  task automatic test_full_list();
    while (shadow_length < LIST_DEPTH) begin
      send_word(REQ_INSERT, POS_W'($urandom_range(shadow_length + 1, 1)),
                DATA_W'($urandom));
    end
    send_word(REQ_INSERT, 8'd1, 32'sd3);
    send_word(REQ_INSERT, POS_W'(LIST_DEPTH + 1), 32'sd3);
    send_word(REQ_INSERT, POS_W'(LIST_DEPTH + 2), 32'sd3);
    send_word(REQ_READ,   POS_W'(LIST_DEPTH), 32'sd0);
    send_word(REQ_REMOVE, POS_W'(LIST_DEPTH), 32'sd0);
    send_word(REQ_REMOVE, 8'd1, 32'sd0);
  endtask

  // Random traffic with bubbles on both sides. The mix alternates between
  // filling and draining every 40 words, so the length sweeps end to end.
  task automatic test_random_traffic(int unsigned num_words);
    idle_on = 1'b1;
    for (int unsigned k = 0; k < num_words; k++) begin
      issue_random_request(((k / 40) % 2) == 0);
    end
  endtask

  // Same traffic with no bubbles at all, so words stream at full rate.
  task automatic test_back_to_back(int unsigned num_words);
    idle_on = 1'b0;
    for (int unsigned k = 0; k < num_words; k++) begin
      issue_random_request(((k / 30) % 2) == 1);
    end
    idle_on = 1'b1;
  endtask

  // The result side stalls at random, driven at falling edges like the inputs.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !(idle_on && $urandom_range(99) < 30);
    end
  end

  // Every accepted result word is checked against the oldest expectation.
  // Outputs are read right at the rising edge, before the block updates them.
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, status %0d count %0d value %0d",
                 $time, out_status, out_entry_count, out_read_value);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_read_value !== exp_res.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch, expected %0d, actual %0d",
                   $time, exp_res.read_value, out_read_value);
        end
        if (out_status !== exp_res.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_res.status, out_status);
        end
        if (out_entry_count !== exp_res.entry_count) begin
          error_count++;
          $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                   $time, exp_res.entry_count, out_entry_count);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("positional_list_engine test failed");
    $finish;
  end

  initial begin
    // All inputs start at known values, and reset is held low at the start.
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_INSERT;
    in_position   = '0;
    in_value      = '0;
    idle_on       = 1'b1;
    error_count   = 0;
    shadow_length = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_boundary_values();
    test_full_list();
    // Let the pipeline run dry before the random part starts.
    wait_for_results();
    test_random_traffic(250);
    test_back_to_back(150);
    wait_for_results();
    test_random_traffic(300);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ple_pkg.sv
sv/ple_decode.sv
sv/ple_store.sv
sv/positional_list_engine.sv
sv/ple_checker.sv
dv/tb_positional_list_engine.sv
